// ----- rtl/core/stis_pkg.sv -----
// Shared constants and types for the sorted-table interpolation search block.
`default_nettype none

package stis_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int VALUE_W     = 32;
    localparam int KEY_W       = 32;
    localparam int COUNT_W     = ADDR_W + 1;
    // The quotient of one probe never exceeds high - low, so it fits in ADDR_W bits.
    localparam int QUO_W       = ADDR_W;
    localparam int STEP_W      = $clog2(QUO_W);
    localparam int PROD_W      = VALUE_W + QUO_W;

    localparam int S_TDATA_W   = ((ADDR_W + VALUE_W + KEY_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((ADDR_W + COUNT_W + 7) / 8) * 8;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOP,
        ST_RD_HIGH,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_PROBE,
        ST_CMP,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/sorted_table_interpolation_search.sv -----
// Top level of the sorted-table interpolation search block.
//
// The block keeps a table of 1024 signed 32-bit values in one synchronous RAM.
// Requests arrive on the s_ stream. A write request (operation 0) stores
// entry_value at entry_index and gives no result. A search request
// (operation 1) runs an interpolation search for search_key over the first
// entry_count entries and gives one result on the m_ stream: found, position
// and probe_count.
// Each probe is paced by the single RAM read port and the serial divider: two
// RAM reads for the bound values, a check, the 32 x 10 product, a bit-per-cycle
// restoring divider for the 10-bit quotient, and a read and compare of the
// probed entry; with equal bound values the product and the divider are
// skipped. One request is in work at a time.
// entry_count is written through cfg_wr_en / cfg_wr_data; the user must do so
// only while the block is idle; the block itself does not enforce this. Values
// above 1024 act as 1024. Reset clears the control state and entry_count; the
// table contents are undefined until written. A result waits in the output
// register while m_tready is low, and a new request is taken meanwhile; a
// finished search holds until the output register frees up.
`default_nettype none

module sorted_table_interpolation_search (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration: entry_count.
    input  wire logic                           cfg_wr_en,
    input  wire logic [stis_pkg::COUNT_W-1:0]   cfg_wr_data,
    // Request stream.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // tdata fields from bit 0: entry_index[9:0], entry_value[41:10],
    // search_key[73:42], zero fill up to bit 79.
    input  wire logic [stis_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser fields from bit 0: operation.
    input  wire logic                           s_tuser,
    // Result stream.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // tdata fields from bit 0: position[9:0], probe_count[20:10], zero fill.
    output logic [stis_pkg::M_TDATA_W-1:0]      m_tdata,
    // tuser fields from bit 0: found.
    output logic                                m_tuser
);

    localparam int AW = stis_pkg::ADDR_W;
    localparam int VW = stis_pkg::VALUE_W;
    localparam int KW = stis_pkg::KEY_W;
    localparam int CW = stis_pkg::COUNT_W;
    localparam int QW = stis_pkg::QUO_W;
    localparam int SW = stis_pkg::STEP_W;
    localparam int PW = stis_pkg::PROD_W;

    // Request fields.
    logic [AW-1:0]        s_entry_index;
    logic [VW-1:0]        s_entry_value;
    logic signed [KW-1:0] s_search_key;
    logic                 s_accept;

    assign s_entry_index = s_tdata[AW-1:0];
    assign s_entry_value = s_tdata[AW+VW-1:AW];
    assign s_search_key  = s_tdata[AW+VW+KW-1:AW+VW];

    // Control and datapath registers.
    stis_pkg::state_t     state_reg, state_next;
    logic [CW-1:0]        count_reg;
    logic signed [KW-1:0] key_reg, key_next;
    logic [CW-1:0]        low_reg, low_next;
    // One past the upper bound, so an empty range is low == high_p1.
    logic [CW-1:0]        high_p1_reg, high_p1_next;
    logic signed [VW-1:0] tl_reg, tl_next;
    logic [VW-1:0]        num_reg, num_next;
    logic [VW-1:0]        den_reg, den_next;
    logic [QW-1:0]        span_reg, span_next;
    logic [PW-1:0]        rem_reg, rem_next;
    logic [QW-1:0]        quo_reg, quo_next;
    logic [SW-1:0]        step_reg, step_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        probes_reg, probes_next;
    logic                 res_found_reg, res_found_next;
    logic [AW-1:0]        res_pos_reg, res_pos_next;

    // Output register.
    logic                 m_valid_reg, m_valid_next;
    logic                 m_found_reg, m_found_next;
    logic [AW-1:0]        m_pos_reg, m_pos_next;
    logic [CW-1:0]        m_probes_reg, m_probes_next;

    // Table RAM.
    logic [VW-1:0]        table_mem [0:stis_pkg::TABLE_DEPTH-1];
    logic [AW-1:0]        rd_addr;
    logic [VW-1:0]        rd_data_reg;
    logic                 wr_en;

    // Helpers.
    logic [CW-1:0]        count_clamped;
    logic signed [VW-1:0] rd_value;
    logic                 out_free;
    logic                 key_out_of_range;
    logic [VW:0]          key_minus_tl;
    logic [VW:0]          th_minus_tl;
    logic [CW-1:0]        high_idx;
    logic [CW-1:0]        span_wide;
    logic [PW-1:0]        den_shifted;
    logic [AW-1:0]        probe_pos;

    assign s_accept      = s_tvalid && s_tready;
    assign s_tready      = (state_reg == stis_pkg::ST_IDLE);
    assign wr_en         = s_accept && (s_tuser == stis_pkg::OP_WRITE);
    assign out_free      = !m_valid_reg || m_tready;
    assign count_clamped = (count_reg > CW'(stis_pkg::TABLE_DEPTH))
                         ? CW'(stis_pkg::TABLE_DEPTH) : count_reg;
    assign rd_value      = $signed(rd_data_reg);
    assign high_idx      = high_p1_reg - CW'(1);
    assign span_wide     = high_idx - low_reg;
    assign key_minus_tl  = {key_reg[KW-1], key_reg} - {tl_reg[VW-1], tl_reg};
    assign th_minus_tl   = {rd_value[VW-1], rd_value} - {tl_reg[VW-1], tl_reg};
    assign key_out_of_range = (key_reg < tl_reg) || (key_reg > rd_value);
    assign den_shifted   = PW'(den_reg) << step_reg;
    assign probe_pos     = low_reg[AW-1:0] + quo_reg;

    // The RAM: one write port for write requests and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[s_entry_index] <= s_entry_value;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    // Read address follows the step of the probe loop.
    always_comb begin
        unique case (state_reg)
            stis_pkg::ST_LOOP:    rd_addr = low_reg[AW-1:0];
            stis_pkg::ST_RD_HIGH: rd_addr = high_idx[AW-1:0];
            stis_pkg::ST_PROBE:   rd_addr = probe_pos;
            default:              rd_addr = '0;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stis_pkg::ST_IDLE: begin
                if (s_accept && (s_tuser == stis_pkg::OP_SEARCH)) begin
                    state_next = stis_pkg::ST_LOOP;
                end
            end
            stis_pkg::ST_LOOP: begin
                if (low_reg < high_p1_reg) begin
                    state_next = stis_pkg::ST_RD_HIGH;
                end else begin
                    state_next = stis_pkg::ST_DONE;
                end
            end
            stis_pkg::ST_RD_HIGH: state_next = stis_pkg::ST_CHECK;
            stis_pkg::ST_CHECK: begin
                if (key_out_of_range) begin
                    state_next = stis_pkg::ST_DONE;
                end else if (rd_value == tl_reg) begin
                    state_next = stis_pkg::ST_PROBE;
                end else begin
                    state_next = stis_pkg::ST_MUL;
                end
            end
            stis_pkg::ST_MUL: state_next = stis_pkg::ST_DIV;
            stis_pkg::ST_DIV: begin
                if (step_reg == '0) begin
                    state_next = stis_pkg::ST_PROBE;
                end
            end
            stis_pkg::ST_PROBE: state_next = stis_pkg::ST_CMP;
            stis_pkg::ST_CMP: begin
                if (rd_value == key_reg) begin
                    state_next = stis_pkg::ST_DONE;
                end else begin
                    state_next = stis_pkg::ST_LOOP;
                end
            end
            stis_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = stis_pkg::ST_IDLE;
                end
            end
            default: state_next = stis_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        key_next       = key_reg;
        low_next       = low_reg;
        high_p1_next   = high_p1_reg;
        tl_next        = tl_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        span_next      = span_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;
        probes_next    = probes_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_found_next   = m_found_reg;
        m_pos_next     = m_pos_reg;
        m_probes_next  = m_probes_reg;

        unique case (state_reg)
            stis_pkg::ST_IDLE: begin
                if (s_accept && (s_tuser == stis_pkg::OP_SEARCH)) begin
                    key_next       = s_search_key;
                    low_next       = '0;
                    high_p1_next   = count_clamped;
                    probes_next    = '0;
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                end
            end
            stis_pkg::ST_RD_HIGH: begin
                tl_next = rd_value;
            end
            stis_pkg::ST_CHECK: begin
                if (!key_out_of_range) begin
                    probes_next = probes_reg + CW'(1);
                    num_next    = key_minus_tl[VW-1:0];
                    den_next    = th_minus_tl[VW-1:0];
                    span_next   = span_wide[QW-1:0];
                    quo_next    = '0;
                end
            end
            stis_pkg::ST_MUL: begin
                rem_next  = PW'(num_reg) * PW'(span_reg);
                step_next = SW'(QW - 1);
            end
            stis_pkg::ST_DIV: begin
                // Restoring division, one quotient bit per cycle.
                if (rem_reg >= den_shifted) begin
                    rem_next           = rem_reg - den_shifted;
                    quo_next[step_reg] = 1'b1;
                end
                step_next = step_reg - SW'(1);
            end
            stis_pkg::ST_PROBE: begin
                pos_next = probe_pos;
            end
            stis_pkg::ST_CMP: begin
                if (rd_value == key_reg) begin
                    res_found_next = 1'b1;
                    res_pos_next   = pos_reg;
                end else if (rd_value < key_reg) begin
                    low_next = CW'(pos_reg) + CW'(1);
                end else begin
                    high_p1_next = CW'(pos_reg);
                end
            end
            stis_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_found_next  = res_found_reg;
                    m_pos_next    = res_pos_reg;
                    m_probes_next = probes_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= stis_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        key_reg       <= key_next;
        low_reg       <= low_next;
        high_p1_reg   <= high_p1_next;
        tl_reg        <= tl_next;
        num_reg       <= num_next;
        den_reg       <= den_next;
        span_reg      <= span_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        step_reg      <= step_next;
        pos_reg       <= pos_next;
        probes_reg    <= probes_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        m_found_reg   <= m_found_next;
        m_pos_reg     <= m_pos_next;
        m_probes_reg  <= m_probes_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {{(stis_pkg::M_TDATA_W - AW - CW){1'b0}}, m_probes_reg, m_pos_reg};

endmodule

`default_nettype wire
